FILE: src/lrua_pkg.sv
// Shared types and constants for the LRU accumulation context allocator.
// No dependencies; compiled first.
package lrua_pkg;

    localparam int CONTEXTS_DEF = 8;   // default number of accumulation contexts
    localparam int ROW_BITS_DEF = 16;  // default significant row bits
    localparam int ROW_W        = 16;  // row field width on the input channel
    localparam int CTX_W        = 3;   // context field width on the output channel

    typedef struct packed {
        logic             stream_start;
        logic             slot_valid;
        logic [ROW_W-1:0] row;
    } t_req;

endpackage

FILE: src/lrua_in_if.sv
// Slot input channel: valid/ready plus one slot beat.
// Depends on lrua_pkg.
interface lrua_in_if;
    import lrua_pkg::*;

    logic             valid;
    logic             ready;
    logic             stream_start;
    logic             slot_valid;
    logic [ROW_W-1:0] row;

    modport source (output valid, output stream_start, output slot_valid, output row,
                    input ready);
    modport sink   (input valid, input stream_start, input slot_valid, input row,
                    output ready);
endinterface

FILE: src/lrua_out_if.sv
// Context result channel: valid/ready plus one context index beat.
// Depends on lrua_pkg.
interface lrua_out_if;
    import lrua_pkg::*;

    logic             valid;
    logic             ready;
    logic [CTX_W-1:0] context_res;

    modport source (output valid, output context_res, input ready);
    modport sink   (input valid, input context_res, output ready);
endinterface

FILE: src/lru_accumulation_context_allocator_core.sv
// Top level of the LRU accumulation context allocator: slot register, context
// table and result register. Depends on lrua_pkg, lrua_in_if, lrua_out_if, lrua_table.
//
// Usage:
//   i_in carries one slot per beat: stream_start, slot_valid and a row index.
//   o_out returns one context index per slot, in slot order. Empty slots
//   return context 0 and, unless stream_start clears it, leave the table untouched.
//   stream_start clears every context before its own slot is looked up.
// Timing:
//   A slot is registered in the input register on acceptance, then matched,
//   allocated and its result registered once the result register is free;
//   a stall on o_out.ready can hold it in the input register in between.
//   Throughput is one slot per cycle while o_out.ready stays high, set by the
//   match/rank update loop in the context table.
// Reset:
//   i_rst_n (synchronous) empties both pipeline registers and marks every
//   context free; no clearing pass is needed.
// Backpressure:
//   While o_out.ready is low the result holds; one more slot can wait in the
//   input register, after which i_in.ready drops.
module lru_accumulation_context_allocator_core #(
    parameter int CONTEXTS = lrua_pkg::CONTEXTS_DEF,
    parameter int ROW_BITS = lrua_pkg::ROW_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lrua_in_if.sink         i_in,
    lrua_out_if.source      o_out
);
    import lrua_pkg::*;

    logic             r_in_vld;
    t_req             r_req;
    logic             r_out_vld;
    logic [CTX_W-1:0] r_ctx;

    logic             w_out_free;
    logic             w_fire;
    logic [CTX_W-1:0] w_ctx;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_fire     = r_in_vld && w_out_free;
    assign i_in.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) r_in_vld <= i_in.valid;
            if (w_out_free) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req.stream_start <= i_in.stream_start;
            r_req.slot_valid   <= i_in.slot_valid;
            r_req.row          <= i_in.row;
        end
        if (w_fire) r_ctx <= w_ctx;
    end

    lrua_table #(
        .CONTEXTS (CONTEXTS),
        .ROW_BITS (ROW_BITS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_fire),
        .i_req         (r_req),
        .o_context_res (w_ctx)
    );

    assign o_out.valid       = r_out_vld;
    assign o_out.context_res = r_ctx;

    // a processed slot always lands in the result register
    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_vld)
        else $error("processed slot did not produce a result beat");

    // empty slots get context 0
    a_empty_ctx0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_req.slot_valid) |=> (r_ctx == '0))
        else $error("empty slot was given a nonzero context");

    // the same row twice in a row, without a stream start between, reuses its context
    a_reuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_req.slot_valid) ##1
        (w_fire && r_req.slot_valid && !r_req.stream_start && (r_req.row == $past(r_req.row)))
        |=> (r_ctx == $past(r_ctx)))
        else $error("resident row was given a different context");

endmodule

FILE: src/lrua_table.sv
// Context table: combinational parallel tag match, free/LRU pick and rank update.
// Depends on lrua_pkg.
module lrua_table #(
    parameter int CONTEXTS = lrua_pkg::CONTEXTS_DEF,
    parameter int ROW_BITS = lrua_pkg::ROW_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  lrua_pkg::t_req               i_req,
    output logic [lrua_pkg::CTX_W-1:0]   o_context_res
);
    import lrua_pkg::*;

    localparam int IDX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

    logic [CONTEXTS-1:0]              r_valid;
    logic [IDX_W-1:0]                 r_rec [CONTEXTS];
    logic [ROW_BITS-1:0]              r_row [CONTEXTS];

    logic [CONTEXTS-1:0]              n_valid;
    logic [IDX_W-1:0]                 n_rec [CONTEXTS];

    logic [31:0]                      w_row_ext;
    logic [ROW_BITS-1:0]              w_row;
    logic [CONTEXTS-1:0]              w_v;
    logic [IDX_W-1:0]                 w_rec [CONTEXTS];
    logic [CONTEXTS-1:0]              w_hit;
    logic [CONTEXTS-1:0]              w_free;
    logic [CONTEXTS-1:0]              w_lru;
    logic [CONTEXTS-1:0]              w_hit_low;
    logic [CONTEXTS-1:0]              w_free_low;
    logic [CONTEXTS-1:0]              w_lru_low;
    logic [CONTEXTS-1:0]              w_sel_oh;
    logic [CONTEXTS-1:0]              w_age;
    logic                             w_hit_any;
    logic [IDX_W-1:0]                 w_hit_rec;
    logic [IDX_W-1:0]                 w_sel_idx;
    logic [31:0]                      w_sel_ext;

    assign w_row_ext = 32'(i_req.row);
    assign w_row     = w_row_ext[ROW_BITS-1:0];

    // stream_start clears the table before this slot is looked up
    always_comb begin
        for (int k = 0; k < CONTEXTS; k++) begin
            w_v[k]   = r_valid[k] & ~i_req.stream_start;
            w_rec[k] = i_req.stream_start ? '0 : r_rec[k];
            w_hit[k] = w_v[k] && (r_row[k] == w_row);
            // full table holds a permutation of ranks, so the oldest has the top rank
            w_lru[k] = w_v[k] && (w_rec[k] == IDX_W'(CONTEXTS - 1));
        end
    end

    assign w_free     = ~w_v;
    assign w_hit_any  = |w_hit;
    assign w_hit_low  = w_hit  & (~w_hit  + CONTEXTS'(1));
    assign w_free_low = w_free & (~w_free + CONTEXTS'(1));
    assign w_lru_low  = w_lru  & (~w_lru  + CONTEXTS'(1));

    always_comb begin
        priority if (w_hit_any) begin
            w_sel_oh = w_hit_low;
        end else if (|w_free) begin
            w_sel_oh = w_free_low;
        end else begin
            w_sel_oh = w_lru_low;
        end
    end

    always_comb begin
        w_hit_rec = '0;
        w_sel_idx = '0;
        for (int k = 0; k < CONTEXTS; k++) begin
            if (w_hit_low[k]) w_hit_rec = w_hit_rec | w_rec[k];
            if (w_sel_oh[k])  w_sel_idx = w_sel_idx | IDX_W'(k);
        end
    end

    // on a hit only entries younger than the hit entry age; on a miss all valid ones do
    always_comb begin
        for (int k = 0; k < CONTEXTS; k++) begin
            w_age[k] = !w_sel_oh[k] && w_v[k] && (!w_hit_any || (w_rec[k] < w_hit_rec));
            if (i_req.slot_valid && w_sel_oh[k]) begin
                n_valid[k] = 1'b1;
                n_rec[k]   = '0;
            end else begin
                n_valid[k] = w_v[k];
                n_rec[k]   = (i_req.slot_valid && w_age[k]) ? w_rec[k] + IDX_W'(1) : w_rec[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int k = 0; k < CONTEXTS; k++) r_rec[k] <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
            for (int k = 0; k < CONTEXTS; k++) r_rec[k] <= n_rec[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CONTEXTS; k++) begin
            if (i_en && i_req.slot_valid && w_sel_oh[k]) r_row[k] <= w_row;
        end
    end

    assign w_sel_ext     = 32'(w_sel_idx);
    assign o_context_res = i_req.slot_valid ? w_sel_ext[CTX_W-1:0] : '0;

endmodule
